@@ rtl/core/sfd_pkg.sv @@
// Shared types and constants for the SBUS frame decoder.
`default_nettype none

package sfd_pkg;

	localparam int CHANNEL_COUNT = 16;
	localparam int FRAME_BYTES   = 25;
	localparam int PAYLOAD_BYTES = 22;
	localparam int FLAG_POS      = 23;

	localparam int BYTE_W    = 8;
	localparam int RAW_W     = 11;
	localparam int OUT_W     = 12;
	localparam int CH_W      = 4;
	localparam int POS_W     = 5;
	localparam int PAYLOAD_W = PAYLOAD_BYTES * BYTE_W;

	// Datapath widths: signed raw offset, signed output span, their product,
	// the product magnitude, the divide remainder and step count, and the value before clamping.
	localparam int DIFF_W = RAW_W + 1;
	localparam int SPAN_W = OUT_W + 1;
	localparam int PROD_W = DIFF_W + SPAN_W;
	localparam int MAG_W  = PROD_W - 1;
	localparam int REM_W  = RAW_W + 1;
	localparam int CNT_W  = 5;
	localparam int VAL_W  = MAG_W + 2;

	localparam logic [BYTE_W-1:0] START_BYTE   = 8'h0F;
	localparam int                LOST_BIT     = 2;
	localparam int                FAILSAFE_BIT = 3;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = OUT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 4'd3;

	localparam logic [RAW_W-1:0] RAW_MIN_RST = 11'd172;
	localparam logic [RAW_W-1:0] RAW_MAX_RST = 11'd1811;
	localparam logic [OUT_W-1:0] OUT_MIN_RST = 12'd1000;
	localparam logic [OUT_W-1:0] OUT_MAX_RST = 12'd2000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/sbus_frame_decoder.sv @@
// SBUS frame decoder top level: byte collection, channel unpack and rescale sequencer.
`default_nettype none

// Bytes are taken one per cycle while the block waits for or collects a frame;
// bytes other than 0x0F are dropped until a start byte arrives. Once the 25th
// byte is taken, rx_stall stays high while the sixteen channels are worked
// out one after another by a shared multiply and restoring divide unit: the
// product is registered in ST_MUL, ST_DIV yields one quotient bit per cycle,
// ST_FIN applies sign, offset and clamp, then the result beat waits as long as
// chan_stall is high. When raw_max equals raw_min the divide is skipped.
// Configuration writes are always taken, one per cycle.

module sbus_frame_decoder (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               rx_valid,
	output logic                                    rx_stall,
	input  wire logic [sfd_pkg::BYTE_W-1:0]         rx_byte,
	output logic                                    chan_valid,
	input  wire logic                               chan_stall,
	output logic [sfd_pkg::CH_W-1:0]                chan_index,
	output logic [sfd_pkg::RAW_W-1:0]               chan_raw,
	output logic [sfd_pkg::OUT_W-1:0]               chan_value,
	output logic                                    signal_lost,
	output logic                                    failsafe_active,
	output logic                                    last_channel,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	sfd_pkg::state_t state_q, state_d;

	logic [sfd_pkg::RAW_W-1:0]     raw_min_q, raw_max_q;
	logic [sfd_pkg::OUT_W-1:0]     out_min_q, out_max_q;
	logic [sfd_pkg::POS_W-1:0]     pos_q;
	logic [sfd_pkg::CH_W-1:0]      ch_q;
	logic [sfd_pkg::PAYLOAD_W-1:0] payload_q;
	logic                          lost_q, fs_q;
	logic                          neg_q;
	logic [sfd_pkg::RAW_W-1:0]     den_mag_q;
	logic [sfd_pkg::MAG_W-1:0]     dvd_q;
	logic [sfd_pkg::REM_W-1:0]     rem_q;
	logic [sfd_pkg::CNT_W-1:0]     cnt_q;
	logic [sfd_pkg::OUT_W-1:0]     value_q;

	logic rx_take, chan_take, cfg_take, frame_done, den_zero, div_last, ch_last;

	logic signed [sfd_pkg::DIFF_W-1:0] diff;
	logic signed [sfd_pkg::SPAN_W-1:0] span;
	logic signed [sfd_pkg::PROD_W-1:0] prod;
	logic        [sfd_pkg::PROD_W-1:0] prod_abs;
	logic signed [sfd_pkg::DIFF_W-1:0] den;
	logic        [sfd_pkg::DIFF_W-1:0] den_abs;

	logic [sfd_pkg::REM_W-1:0] rem_sh;
	logic                      q_bit;

	logic signed [sfd_pkg::VAL_W-1:0] quot_s, lo_s, hi_s, sum_s;
	logic        [sfd_pkg::OUT_W-1:0] clamped;

	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid & cfg_ready;
	assign rx_stall  = (state_q != sfd_pkg::ST_IDLE);
	assign rx_take   = rx_valid & ~rx_stall;
	assign chan_take = chan_valid & ~chan_stall;

	assign frame_done = rx_take && (pos_q == sfd_pkg::POS_W'(sfd_pkg::FRAME_BYTES - 1));
	assign ch_last    = (ch_q == sfd_pkg::CH_W'(sfd_pkg::CHANNEL_COUNT - 1));
	assign div_last   = (cnt_q == sfd_pkg::CNT_W'(sfd_pkg::MAG_W - 1));

	// Product of the raw offset and the output span, and the signed divisor.
	assign diff     = $signed({1'b0, payload_q[sfd_pkg::RAW_W-1:0]}) - $signed({1'b0, raw_min_q});
	assign span     = $signed({1'b0, out_max_q}) - $signed({1'b0, out_min_q});
	assign prod     = diff * span;
	assign prod_abs = prod[sfd_pkg::PROD_W-1] ? sfd_pkg::PROD_W'(-prod) : prod;
	assign den      = $signed({1'b0, raw_max_q}) - $signed({1'b0, raw_min_q});
	assign den_abs  = den[sfd_pkg::DIFF_W-1] ? sfd_pkg::DIFF_W'(-den) : den;
	assign den_zero = (den == '0);

	// One restoring divide step.
	assign rem_sh = {rem_q[sfd_pkg::REM_W-2:0], dvd_q[sfd_pkg::MAG_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, den_mag_q});

	// Quotient truncated toward zero, offset by out_min, clamped floor first.
	assign quot_s = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
	assign lo_s   = $signed({{(sfd_pkg::VAL_W - sfd_pkg::OUT_W){1'b0}}, out_min_q});
	assign hi_s   = $signed({{(sfd_pkg::VAL_W - sfd_pkg::OUT_W){1'b0}}, out_max_q});
	assign sum_s  = quot_s + lo_s;

	always_comb begin
		if (sum_s < lo_s) begin
			clamped = out_min_q;
		end else if (sum_s > hi_s) begin
			clamped = out_max_q;
		end else begin
			clamped = sum_s[sfd_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		chan_valid = 1'b0;
		case (state_q)
			sfd_pkg::ST_IDLE: begin
				if (frame_done) begin
					state_d = sfd_pkg::ST_MUL;
				end
			end
			sfd_pkg::ST_MUL: begin
				state_d = den_zero ? sfd_pkg::ST_OUT : sfd_pkg::ST_DIV;
			end
			sfd_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = sfd_pkg::ST_FIN;
				end
			end
			sfd_pkg::ST_FIN: begin
				state_d = sfd_pkg::ST_OUT;
			end
			sfd_pkg::ST_OUT: begin
				chan_valid = 1'b1;
				if (!chan_stall) begin
					state_d = ch_last ? sfd_pkg::ST_IDLE : sfd_pkg::ST_MUL;
				end
			end
			default: begin
				state_d = sfd_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_min_q <= sfd_pkg::RAW_MIN_RST;
			raw_max_q <= sfd_pkg::RAW_MAX_RST;
			out_min_q <= sfd_pkg::OUT_MIN_RST;
			out_max_q <= sfd_pkg::OUT_MAX_RST;
		end else if (cfg_take) begin
			case (cfg_index)
				sfd_pkg::CFG_RAW_MIN: raw_min_q <= cfg_data[sfd_pkg::RAW_W-1:0];
				sfd_pkg::CFG_RAW_MAX: raw_max_q <= cfg_data[sfd_pkg::RAW_W-1:0];
				sfd_pkg::CFG_OUT_MIN: out_min_q <= cfg_data;
				sfd_pkg::CFG_OUT_MAX: out_max_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Byte position and channel counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ch_q  <= '0;
		end else begin
			if (rx_take) begin
				if (pos_q == '0) begin
					if (rx_byte == sfd_pkg::START_BYTE) begin
						pos_q <= sfd_pkg::POS_W'(1);
					end
				end else if (frame_done) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + sfd_pkg::POS_W'(1);
				end
			end
			if (frame_done) begin
				ch_q <= '0;
			end else if (chan_take && !ch_last) begin
				ch_q <= ch_q + sfd_pkg::CH_W'(1);
			end
		end
	end

	// Payload shift line, flags and the divide unit.
	always_ff @(posedge clk) begin
		if (rx_take && pos_q != '0
			&& pos_q <= sfd_pkg::POS_W'(sfd_pkg::PAYLOAD_BYTES)) begin
			payload_q <= {rx_byte, payload_q[sfd_pkg::PAYLOAD_W-1:sfd_pkg::BYTE_W]};
		end else if (chan_take) begin
			payload_q <= payload_q >> sfd_pkg::RAW_W;
		end
		if (rx_take && pos_q == sfd_pkg::POS_W'(sfd_pkg::FLAG_POS)) begin
			lost_q <= rx_byte[sfd_pkg::LOST_BIT];
			fs_q   <= rx_byte[sfd_pkg::FAILSAFE_BIT];
		end
		case (state_q)
			sfd_pkg::ST_MUL: begin
				neg_q     <= prod[sfd_pkg::PROD_W-1] ^ den[sfd_pkg::DIFF_W-1];
				dvd_q     <= prod_abs[sfd_pkg::MAG_W-1:0];
				den_mag_q <= den_abs[sfd_pkg::RAW_W-1:0];
				rem_q     <= '0;
				cnt_q     <= '0;
				value_q   <= out_min_q;
			end
			sfd_pkg::ST_DIV: begin
				rem_q <= q_bit ? (rem_sh - {1'b0, den_mag_q}) : rem_sh;
				dvd_q <= {dvd_q[sfd_pkg::MAG_W-2:0], q_bit};
				cnt_q <= cnt_q + sfd_pkg::CNT_W'(1);
			end
			sfd_pkg::ST_FIN: begin
				value_q <= clamped;
			end
			default: begin
			end
		endcase
	end

	assign chan_index      = ch_q;
	assign chan_raw        = payload_q[sfd_pkg::RAW_W-1:0];
	assign chan_value      = value_q;
	assign signal_lost     = lost_q;
	assign failsafe_active = fs_q;
	assign last_channel    = ch_last;

endmodule

`default_nettype wire

@@ rtl/core/sfd_checker.sv @@
// Port-level assertions for the SBUS frame decoder and their bind.
`default_nettype none

module sfd_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           rx_stall,
	input wire logic                           chan_valid,
	input wire logic                           chan_stall,
	input wire logic [sfd_pkg::CH_W-1:0]       chan_index,
	input wire logic                           last_channel
);

	// A result beat stalled on the output side stays offered.
	a_chan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid && chan_stall |=> chan_valid)
		else $error("result beat dropped while stalled");

	// The final beat of a frame is always channel fifteen.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid && last_channel |-> chan_index == sfd_pkg::CH_W'(sfd_pkg::CHANNEL_COUNT - 1))
		else $error("last_channel flagged on wrong channel");

	// No byte is taken while results of a frame are still pending.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid && !chan_stall && !last_channel |=> rx_stall)
		else $error("byte input reopened in the middle of a frame");

	// After the last beat of a frame the byte input opens again.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid && !chan_stall && last_channel |=> !rx_stall && !chan_valid)
		else $error("decoder did not return to idle after the frame");

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_stall     (rx_stall),
	.chan_valid   (chan_valid),
	.chan_stall   (chan_stall),
	.chan_index   (chan_index),
	.last_channel (last_channel)
);

`default_nettype wire

@@ verif/sbus_frame_decoder_tb.sv @@
// Self-checking testbench for the SBUS frame decoder: random frames, stalls and register settings.
`timescale 1ns / 100ps

module sbus_frame_decoder_tb;

	localparam int MAX_REPORTS   = 10;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 800;
	localparam int CYCLE_LIMIT   = 200000;

	// Writes here must be dropped by the block.
	localparam logic [sfd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'hF;

	typedef struct packed {
		logic [sfd_pkg::CH_W-1:0]  idx;
		logic [sfd_pkg::RAW_W-1:0] raw;
		logic [sfd_pkg::OUT_W-1:0] value;
		logic                      lost;
		logic                      failsafe;
		logic                      last;
	} chan_beat_t;

	class frame_scoreboard;
		chan_beat_t                 expected_chans[$];
		logic [sfd_pkg::BYTE_W-1:0] frame_bytes[sfd_pkg::FRAME_BYTES];
		int                         fill;
		logic [sfd_pkg::RAW_W-1:0]  raw_lo, raw_hi;
		logic [sfd_pkg::OUT_W-1:0]  out_lo, out_hi;
		int                         mismatches;

		function new();
			fill       = 0;
			raw_lo     = sfd_pkg::RAW_MIN_RST;
			raw_hi     = sfd_pkg::RAW_MAX_RST;
			out_lo     = sfd_pkg::OUT_MIN_RST;
			out_hi     = sfd_pkg::OUT_MAX_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [sfd_pkg::CFG_IDX_W-1:0] idx,
				logic [sfd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				sfd_pkg::CFG_RAW_MIN: raw_lo = data[sfd_pkg::RAW_W-1:0];
				sfd_pkg::CFG_RAW_MAX: raw_hi = data[sfd_pkg::RAW_W-1:0];
				sfd_pkg::CFG_OUT_MIN: out_lo = data;
				sfd_pkg::CFG_OUT_MAX: out_hi = data;
				default: ;
			endcase
		endfunction

		// Signed linear map with truncating division; the floor is tested before the ceiling.
		function logic [sfd_pkg::OUT_W-1:0] scale_channel(logic [sfd_pkg::RAW_W-1:0] raw);
			int lo, hi, den, v;
			lo  = out_lo;
			hi  = out_hi;
			den = int'(raw_hi) - int'(raw_lo);
			if (den == 0)
				return out_lo;
			v = (int'(raw) - int'(raw_lo)) * (hi - lo) / den + lo;
			if (v < lo)
				v = lo;
			else if (v > hi)
				v = hi;
			return v[sfd_pkg::OUT_W-1:0];
		endfunction

		function void note_byte(logic [sfd_pkg::BYTE_W-1:0] b);
			logic [sfd_pkg::PAYLOAD_W-1:0] payload;
			chan_beat_t beat;
			if (fill == 0 && b != sfd_pkg::START_BYTE)
				return;
			frame_bytes[fill] = b;
			fill++;
			if (fill < sfd_pkg::FRAME_BYTES)
				return;
			fill = 0;
			for (int k = 0; k < sfd_pkg::PAYLOAD_BYTES; k++)
				payload[k*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = frame_bytes[k+1];
			for (int ch = 0; ch < sfd_pkg::CHANNEL_COUNT; ch++) begin
				beat.idx      = sfd_pkg::CH_W'(ch);
				beat.raw      = payload[ch*sfd_pkg::RAW_W +: sfd_pkg::RAW_W];
				beat.value    = scale_channel(beat.raw);
				beat.lost     = frame_bytes[sfd_pkg::FLAG_POS][sfd_pkg::LOST_BIT];
				beat.failsafe = frame_bytes[sfd_pkg::FLAG_POS][sfd_pkg::FAILSAFE_BIT];
				beat.last     = (ch == sfd_pkg::CHANNEL_COUNT - 1);
				expected_chans.push_back(beat);
			end
		endfunction

		function void check_result(chan_beat_t got);
			chan_beat_t want;
			if (expected_chans.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected channel beat idx=%0d raw=%0d value=%0d",
						$time, got.idx, got.raw, got.value);
				return;
			end
			want = expected_chans.pop_front();
			if (got.idx !== want.idx || got.raw !== want.raw || got.value !== want.value ||
					got.lost !== want.lost || got.failsafe !== want.failsafe ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display({"%0t: channel mismatch, expected idx=%0d raw=%0d value=%0d",
						" lost=%0d fs=%0d last=%0d"},
						$time, want.idx, want.raw, want.value, want.lost, want.failsafe,
						want.last);
					$display({"%0t:                   actual idx=%0d raw=%0d value=%0d",
						" lost=%0d fs=%0d last=%0d"},
						$time, got.idx, got.raw, got.value, got.lost, got.failsafe, got.last);
				end
			end
		endfunction

		function int pending();
			return expected_chans.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           rx_valid = 1'b0;
	logic                           rx_stall;
	logic [sfd_pkg::BYTE_W-1:0]     rx_byte = '0;
	logic                           chan_valid;
	logic                           chan_stall = 1'b0;
	logic [sfd_pkg::CH_W-1:0]       chan_index;
	logic [sfd_pkg::RAW_W-1:0]      chan_raw;
	logic [sfd_pkg::OUT_W-1:0]      chan_value;
	logic                           signal_lost;
	logic                           failsafe_active;
	logic                           last_channel;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic        calm = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_taken = 1'b0;
	int          hold_left = 0;
	bit          rx_on = 1'b0;
	int unsigned cycles = 0;

	frame_scoreboard sb = new();

	sbus_frame_decoder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_valid        (rx_valid),
		.rx_stall        (rx_stall),
		.rx_byte         (rx_byte),
		.chan_valid      (chan_valid),
		.chan_stall      (chan_stall),
		.chan_index      (chan_index),
		.chan_raw        (chan_raw),
		.chan_value      (chan_value),
		.signal_lost     (signal_lost),
		.failsafe_active (failsafe_active),
		.last_channel    (last_channel),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("sbus_frame_decoder verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off on request, none while calm.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			chan_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left  <= hold_left - 1;
			chan_stall <= 1'b1;
		end else begin
			chan_stall <= !calm && ($urandom_range(99) < 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n && chan_valid && !chan_stall)
			sb.check_result({chan_index, chan_raw, chan_value, signal_lost, failsafe_active,
				last_channel});
	end

	// Writes all four registers and the spare index; valid stays high across the beats.
	task automatic set_bounds(input logic [sfd_pkg::CFG_DATA_W-1:0] rmin, rmax, omin, omax);
		logic [sfd_pkg::CFG_IDX_W-1:0]  regs[5];
		logic [sfd_pkg::CFG_DATA_W-1:0] vals[5];
		regs = '{sfd_pkg::CFG_RAW_MIN, sfd_pkg::CFG_RAW_MAX, sfd_pkg::CFG_OUT_MIN,
			sfd_pkg::CFG_OUT_MAX, CFG_SPARE};
		vals = '{rmin, rmax, omin, omax, sfd_pkg::CFG_DATA_W'($urandom)};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
		rx_valid <= 1'b1;
		rx_byte  <= b;
		rx_on = 1'b1;
		do @(posedge clk); while (rx_stall);
		sb.note_byte(b);
		if (!calm && $urandom_range(99) < 9) begin
			rx_valid <= 1'b0;
			rx_on = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_frame(input int noise, input logic [sfd_pkg::PAYLOAD_W-1:0] payload,
			input logic [sfd_pkg::BYTE_W-1:0] flags, input logic [sfd_pkg::BYTE_W-1:0] tail);
		logic [sfd_pkg::BYTE_W-1:0] b;
		// Line noise before the frame must never look like a start byte.
		for (int i = 0; i < noise; i++) begin
			b = sfd_pkg::BYTE_W'($urandom_range(255));
			if (b == sfd_pkg::START_BYTE)
				b ^= 8'h01;
			send_byte(b);
		end
		send_byte(sfd_pkg::START_BYTE);
		for (int k = 0; k < sfd_pkg::PAYLOAD_BYTES; k++)
			send_byte(payload[k*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W]);
		send_byte(flags);
		send_byte(tail);
	endtask

	// Mostly channel picks: bounds and neighbours, 0, all ones, random; else random bytes.
	function automatic logic [sfd_pkg::PAYLOAD_W-1:0] random_payload();
		logic [sfd_pkg::PAYLOAD_W-1:0] p;
		logic [sfd_pkg::RAW_W-1:0]     r;
		if ($urandom_range(3) == 0) begin
			for (int k = 0; k < sfd_pkg::PAYLOAD_BYTES; k++)
				p[k*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = sfd_pkg::BYTE_W'($urandom_range(255));
			return p;
		end
		for (int ch = 0; ch < sfd_pkg::CHANNEL_COUNT; ch++) begin
			case ($urandom_range(7))
				0: r = '0;
				1: r = '1;
				2: r = sb.raw_lo;
				3: r = sb.raw_hi;
				4: r = sb.raw_lo + 1'b1;
				5: r = sb.raw_hi - 1'b1;
				default: r = sfd_pkg::RAW_W'($urandom_range(2047));
			endcase
			p[ch*sfd_pkg::RAW_W +: sfd_pkg::RAW_W] = r;
		end
		return p;
	endfunction

	task automatic random_frame();
		send_frame($urandom_range(0, 3), random_payload(),
			sfd_pkg::BYTE_W'($urandom_range(255)), sfd_pkg::BYTE_W'($urandom_range(255)));
	endtask

	task automatic settle();
		if (rx_on) begin
			rx_valid <= 1'b0;
			rx_on = 1'b0;
		end
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [sfd_pkg::PAYLOAD_W-1:0] payload;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset bounds: idle noise, then a frame whose first eight channels are all ones,
		// the rest zero apart from a start byte value sitting in the data.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h0E);
		payload = '0;
		payload[87:0] = '1;
		payload[13*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = sfd_pkg::START_BYTE;
		send_frame(0, payload, 8'h0C, 8'h00);
		settle();

		// Equal raw bounds force the output floor.
		set_bounds(12'd700, 12'd700, 12'd1234, 12'd4000);
		random_frame();
		settle();

		// Inverted raw bounds over the full ranges; the top data bit of a raw bound is dropped.
		set_bounds(12'hFFF, 12'h000, 12'h000, 12'hFFF);
		random_frame();
		settle();

		// Inverted output bounds, with neither side idling.
		calm <= 1'b1;
		set_bounds(12'd172, 12'd1811, 12'd3000, 12'd500);
		random_frame();
		settle();
		calm <= 1'b0;

		// Random bounds; the receiver holds off while the sender keeps offering idle bytes.
		set_bounds(sfd_pkg::CFG_DATA_W'($urandom), sfd_pkg::CFG_DATA_W'($urandom),
			sfd_pkg::CFG_DATA_W'($urandom), sfd_pkg::CFG_DATA_W'($urandom));
		hold_req <= 1'b1;
		random_frame();
		send_byte(8'h00);
		send_byte(8'hA5);
		settle();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("sbus_frame_decoder verification clean");
		else
			$display("sbus_frame_decoder verification failed");
		$finish;
	end

endmodule

@@ sbus_frame_decoder.f @@
rtl/core/sfd_pkg.sv
rtl/core/sbus_frame_decoder.sv
rtl/core/sfd_checker.sv
verif/sbus_frame_decoder_tb.sv
